[src/fel_pkg.sv]
// Shared types and constants for the fault edge event logger.
`default_nettype none

package fel_pkg;

    localparam int LOG_DEPTH = 64;
    localparam int FAULT_W = 32;
    localparam int TIME_W = 32;
    localparam int BIT_W = 5;
    localparam int CMD_W = 2;
    localparam int IDX_W = 6;
    localparam int HELD_W = 7;

    localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int HELD_MAX = (LOG_DEPTH > 127) ? 127 : LOG_DEPTH;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_READ,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [FAULT_W-1:0] fault_bits;
        logic [TIME_W-1:0]  now_ms;
        logic [IDX_W-1:0]   read_index;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [BIT_W-1:0]  bitnum;
    } entry_t;

endpackage

`default_nettype wire

[src/fel_front.sv]
// Input stage: accepts beats, decodes the command and holds them in a short queue.
`default_nettype none

module fel_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [fel_pkg::CMD_W-1:0]     cmd,
    input  wire logic [fel_pkg::FAULT_W-1:0]   fault_bits,
    input  wire logic [fel_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [fel_pkg::IDX_W-1:0]     read_index,
    output logic                               q_valid,
    output fel_pkg::item_t                     q_item,
    input  wire logic                          q_pop
);
    import fel_pkg::*;

    item_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg;
    logic [QFILL_W-1:0] fill_next;
    logic               push;
    logic               pop;
    item_t              new_item;

    always_comb
    begin
        new_item.fault_bits = fault_bits;
        new_item.now_ms = now_ms;
        new_item.read_index = read_index;
        case (cmd)
            CMD_SAMPLE: new_item.op = OP_SAMPLE;
            CMD_READ:   new_item.op = OP_READ;
            CMD_CLEAR:  new_item.op = OP_CLEAR;
            default:    new_item.op = OP_NONE;
        endcase
    end

    assign in_stall = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item = q_mem[rd_ptr_reg];
    assign push = in_valid && !in_stall;
    assign pop = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

[src/fel_back.sv]
// Execution stage: edge scan, ring log memory, read lookup and the result register.
`default_nettype none

module fel_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire fel_pkg::item_t                q_item,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic [fel_pkg::TIME_W-1:0]         entry_time,
    output logic [fel_pkg::BIT_W-1:0]          entry_bit,
    output logic [fel_pkg::HELD_W-1:0]         entries_held
);
    import fel_pkg::*;

    entry_t             log_mem [LOG_DEPTH];
    entry_t             rd_data_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [FAULT_W-1:0] risen_reg;
    logic [FAULT_W-1:0] risen_next;
    logic [TIME_W-1:0]  stamp_reg;
    logic [TIME_W-1:0]  stamp_next;
    logic [BIT_W-1:0]   bit_reg;
    logic [BIT_W-1:0]   bit_next;
    logic [FAULT_W-1:0] prev_reg;
    logic [FAULT_W-1:0] prev_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               ok_pend_reg;
    logic               ok_pend_next;
    logic               use_mem_reg;
    logic               use_mem_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               ok_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [BIT_W-1:0]   bit_out_reg;
    logic [HELD_W-1:0]  held_reg;

    logic               out_load;
    logic               wr_en;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   start;
    logic [SUM_W-1:0]   slot_sum;
    logic               full;

    assign full = (count_reg == CNT_W'(LOG_DEPTH));
    assign start = full ? wp_reg : '0;
    assign slot_sum = {1'b0, start} + {1'b0, PTR_W'(q_item.read_index)};
    assign rd_addr = (slot_sum >= SUM_W'(LOG_DEPTH))
        ? PTR_W'(slot_sum - SUM_W'(LOG_DEPTH)) : PTR_W'(slot_sum);

    always_comb
    begin
        state_next = state_reg;
        risen_next = risen_reg;
        stamp_next = stamp_reg;
        bit_next = bit_reg;
        prev_next = prev_reg;
        wp_next = wp_reg;
        count_next = count_reg;
        ok_pend_next = ok_pend_reg;
        use_mem_next = use_mem_reg;
        q_pop = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    use_mem_next = 1'b0;
                    case (q_item.op)
                        OP_SAMPLE:
                        begin
                            risen_next = q_item.fault_bits & ~prev_reg;
                            prev_next = q_item.fault_bits;
                            stamp_next = q_item.now_ms;
                            bit_next = '0;
                            ok_pend_next = 1'b1;
                            state_next = ST_SCAN;
                        end
                        OP_READ:
                        begin
                            ok_pend_next = CMP_W'(q_item.read_index) < CMP_W'(count_reg);
                            rd_en = 1'b1;
                            use_mem_next = 1'b1;
                            state_next = ST_EMIT;
                        end
                        OP_CLEAR:
                        begin
                            wp_next = '0;
                            count_next = '0;
                            prev_next = '0;
                            ok_pend_next = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            ok_pend_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (risen_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    if (risen_reg[0])
                    begin
                        wr_en = 1'b1;
                        wp_next = (wp_reg == PTR_W'(LOG_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        if (!full)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    risen_next = risen_reg >> 1;
                    bit_next = bit_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prev_reg <= '0;
            wp_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg <= prev_next;
            wp_reg <= wp_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        risen_reg <= risen_next;
        stamp_reg <= stamp_next;
        bit_reg <= bit_next;
        ok_pend_reg <= ok_pend_next;
        use_mem_reg <= use_mem_next;
        if (out_load)
        begin
            ok_reg <= ok_pend_reg;
            time_reg <= (use_mem_reg && ok_pend_reg) ? rd_data_reg.stamp : '0;
            bit_out_reg <= (use_mem_reg && ok_pend_reg) ? rd_data_reg.bitnum : '0;
            held_reg <= HELD_W'(count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            log_mem[wp_reg] <= '{stamp: stamp_reg, bitnum: bit_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= log_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign ok = ok_reg;
    assign entry_time = time_reg;
    assign entry_bit = bit_out_reg;
    assign entries_held = held_reg;

endmodule

`default_nettype wire

[src/fault_edge_event_logger_core.sv]
// Top level of the fault edge event logger.
//
// Each input beat carries a command: sample the fault word, read one log entry
// by oldest-first index, or clear the log. Every input beat yields exactly one
// output beat with ok, entry_time, entry_bit and the entry count after the command.
// Both channels use valid and stall; a beat moves when valid is high and stall low.
// A two-beat queue sits between the decode stage and the execution stage, so
// input beats are taken while the execution stage is busy or the output is stalled.
// A sample scans the newly risen bits from bit 0 up to the highest one and stops once
// none is left; the scan steps one bit per cycle, writes each new entry into the
// single-port log memory and sets the sustained rate.
// Reset clears the pointers, the count, the previous fault word and both handshakes;
// the log memory itself is not cleared, since only written entries are reachable.
// While out_stall is high the output beat holds, and once the queue fills in_stall rises.
`default_nettype none

module fault_edge_event_logger_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [fel_pkg::CMD_W-1:0]     cmd,
    input  wire logic [fel_pkg::FAULT_W-1:0]   fault_bits,
    input  wire logic [fel_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [fel_pkg::IDX_W-1:0]     read_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic [fel_pkg::TIME_W-1:0]         entry_time,
    output logic [fel_pkg::BIT_W-1:0]          entry_bit,
    output logic [fel_pkg::HELD_W-1:0]         entries_held
);
    import fel_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    fel_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .fault_bits (fault_bits),
        .now_ms     (now_ms),
        .read_index (read_index),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    fel_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .entry_time   (entry_time),
        .entry_bit    (entry_bit),
        .entries_held (entries_held)
    );

endmodule

`default_nettype wire

[src/fel_checker.sv]
// Port-level checks for the fault edge event logger, bound to the top level.
`default_nettype none

module fel_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [fel_pkg::CMD_W-1:0]     cmd,
    input  wire logic [fel_pkg::FAULT_W-1:0]   fault_bits,
    input  wire logic [fel_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [fel_pkg::IDX_W-1:0]     read_index,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          ok,
    input  wire logic [fel_pkg::TIME_W-1:0]    entry_time,
    input  wire logic [fel_pkg::BIT_W-1:0]     entry_bit,
    input  wire logic [fel_pkg::HELD_W-1:0]    entries_held
);
    import fel_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(ok) && $stable(entry_time)
            && $stable(entry_bit) && $stable(entries_held))
        else $error("output beat changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> entry_time == '0 && entry_bit == '0)
        else $error("failed command returned entry data");

    a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_held <= HELD_W'(HELD_MAX))
        else $error("entry count beyond log depth");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(fault_bits)
            && $stable(now_ms) && $stable(read_index))
        else $error("input beat changed while stalled");

endmodule

bind fault_edge_event_logger_core fel_checker u_fel_checker (.*);

`default_nettype wire
